@@ rtl/cpt_pkg.sv @@
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and codes of the triangle closest point unit
// Edge clamp modes, feature codes and the control group that rides the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

  // where an edge point lands on its segment
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_MID   = 2'd2;

  // where the closest point was found
  localparam logic [1:0] FEAT_FACE = 2'd0;
  localparam logic [1:0] FEAT_AB   = 2'd1;
  localparam logic [1:0] FEAT_BC   = 2'd2;
  localparam logic [1:0] FEAT_CA   = 2'd3;

  // control group carried next to the data
  typedef struct packed {
    logic            valid;
    logic            in_face;
    logic [2:0][1:0] mode;
  } ctl_t;

endpackage

`default_nettype wire

@@ rtl/triangle_closest_point_unit.sv @@
// Throughput: one beat per cycle unless the output stalls; the figure is set
// by the divider pipelines, which retire one quotient bit per stage over
// COORD_WIDTH+1 stages.
// A stalled output freezes the whole pipe, so no beat is lost or repeated.
// Reset clears the valid bits and control groups only; the data registers are not reset.
// ----------------------------------------------------------------------------
// triangle_closest_point_unit: closest point of a 3-D triangle to a point
// Face projection when the point projects inside, else nearest clamped edge.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_closest_point_unit import cpt_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_c_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_c_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_c_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_q_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_q_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_q_z,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0]      out_p_x,
  output logic signed [COORD_WIDTH-1:0]      out_p_y,
  output logic signed [COORD_WIDTH-1:0]      out_p_z,
  output logic [1:0]                         out_feature
);

  localparam int NSW = 5*COORD_WIDTH+9;
  localparam int NNW = 4*COORD_WIDTH+8;
  localparam int QW  = COORD_WIDTH+1;

  // whole pipe advances unless a finished beat is held
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic signed [COORD_WIDTH-1:0] a_in [3];
  logic signed [COORD_WIDTH-1:0] b_in [3];
  logic signed [COORD_WIDTH-1:0] c_in [3];
  logic signed [COORD_WIDTH-1:0] q_in [3];

  assign a_in[0] = in_a_x;
  assign a_in[1] = in_a_y;
  assign a_in[2] = in_a_z;
  assign b_in[0] = in_b_x;
  assign b_in[1] = in_b_y;
  assign b_in[2] = in_b_z;
  assign c_in[0] = in_c_x;
  assign c_in[1] = in_c_y;
  assign c_in[2] = in_c_z;
  assign q_in[0] = in_q_x;
  assign q_in[1] = in_q_y;
  assign q_in[2] = in_q_z;

  ctl_t                     ctl4;
  logic [12*COORD_WIDTH-1:0] pts4;
  logic signed [NSW-1:0]    num [9];
  logic        [NNW-1:0]    den [9];
  logic signed [QW:0]       quo [9];

  cpt_front #(.W(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .a_in     (a_in),
    .b_in     (b_in),
    .c_in     (c_in),
    .q_in     (q_in),
    .ctl      (ctl4),
    .pts      (pts4),
    .num      (num),
    .den      (den)
  );

  // nine divider lanes: three per edge, the first three also serve the face
  for (genvar k = 0; k < 9; k++) begin : g_lane
    cpt_div #(.NW(NSW), .DW(NNW), .QW(QW)) u_div (
      .clk (clk),
      .en  (en),
      .num (num[k]),
      .den (den[k]),
      .quo (quo[k])
    );
  end

  // side band delay matching the divider depth
  ctl_t                      ctl_dl_r [QW];
  logic [12*COORD_WIDTH-1:0] pts_dl_r [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) begin
        ctl_dl_r[k] <= '0;
      end
    end else if (en) begin
      ctl_dl_r[0] <= ctl4;
      for (int k = 1; k < QW; k++) begin
        ctl_dl_r[k] <= ctl_dl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pts_dl_r[0] <= pts4;
      for (int k = 1; k < QW; k++) begin
        pts_dl_r[k] <= pts_dl_r[k-1];
      end
    end
  end

  cpt_back #(.W(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl       (ctl_dl_r[QW-1]),
    .pts       (pts_dl_r[QW-1]),
    .quo       (quo),
    .out_valid (out_valid),
    .p_x       (out_p_x),
    .p_y       (out_p_y),
    .p_z       (out_p_z),
    .feature   (out_feature)
  );

  // a held result beat must hold off the input side
  a_stall_prop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("held result beat did not stall the input");

  // the input side stalls only behind a full output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no held result beat");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

endmodule

`default_nettype wire

@@ rtl/cpt_div.sv @@
// ----------------------------------------------------------------------------
// cpt_div: pipelined restoring divider
// Signed dividend over non-negative divisor, one quotient bit per stage,
// quotient truncated toward zero. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_div #(
  parameter int NW = 89,
  parameter int DW = 72,
  parameter int QW = 17
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [NW-1:0] num,
  input  wire logic        [DW-1:0] den,
  output logic signed      [QW:0]   quo
);

  logic [NW-1:0] rem_r [QW-1];
  logic [DW-1:0] den_r [QW-1];
  logic [QW-1:0] q_r   [QW];
  logic          neg_r [QW];
  logic [NW-1:0] mag;

  // magnitude of the dividend
  assign mag = num[NW-1] ? $unsigned(-num) : $unsigned(num);

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [NW-1:0] trial;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic          neg_in;

    if (j == 0) begin : g_first
      assign rem_in = mag;
      assign den_in = den;
      assign q_in   = '0;
      assign neg_in = num[NW-1];
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
      assign neg_in = neg_r[j-1];
    end

    // divisor aligned to this quotient bit
    assign trial = NW'(den_in) << (QW-1-j);

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          q_r[j] <= q_in | (QW'(1) << (QW-1-j));
        end else begin
          q_r[j] <= q_in;
        end
        neg_r[j] <= neg_in;
      end
    end

    if (j < QW-1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= (rem_in >= trial) ? rem_in - trial : rem_in;
          den_r[j] <= den_in;
        end
      end
    end
  end

  // restore the sign
  assign quo = neg_r[QW-1] ? -$signed({1'b0, q_r[QW-1]}) : $signed({1'b0, q_r[QW-1]});

endmodule

`default_nettype wire

@@ rtl/cpt_front.sv @@
// ----------------------------------------------------------------------------
// cpt_front: geometry front end
// Edge vectors, normal, inside test, edge clamping and the dividends and
// divisors of the nine divider lanes, over five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_front import cpt_pkg::*; #(
  parameter  int W   = 16,
  localparam int NSW = 5*W+9,
  localparam int NNW = 4*W+8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic signed [W-1:0] a_in [3],
  input  wire logic signed [W-1:0] b_in [3],
  input  wire logic signed [W-1:0] c_in [3],
  input  wire logic signed [W-1:0] q_in [3],
  output ctl_t                     ctl,
  output logic [12*W-1:0]          pts,
  output logic signed [NSW-1:0]    num [9],
  output logic        [NNW-1:0]    den [9]
);

  localparam int DW1 = W+1;
  localparam int CW  = 2*W+3;
  localparam int EDW = 2*W+4;
  localparam int DDW = 3*W+6;
  localparam int TNW = 3*W+5;
  localparam int LOB = (DDW+1)/2;
  localparam int HIB = DDW-LOB;
  localparam int PHW = HIB+CW;
  localparam int PLW = LOB+1+CW;

  function automatic logic signed [CW-1:0] xmul(input logic signed [DW1-1:0] p, q, r, s);
    return CW'(p) * CW'(q) - CW'(r) * CW'(s);
  endfunction

  function automatic logic signed [EDW-1:0] dots(input logic signed [DW1-1:0] x0, x1, x2,
                                                  y0, y1, y2);
    return EDW'(x0) * EDW'(y0) + EDW'(x1) * EDW'(y1) + EDW'(x2) * EDW'(y2);
  endfunction

  function automatic logic signed [NNW-1:0] dotc(input logic signed [CW-1:0] x0, x1, x2,
                                                  y0, y1, y2);
    return NNW'(x0) * NNW'(y0) + NNW'(x1) * NNW'(y1) + NNW'(x2) * NNW'(y2);
  endfunction

  // stage 1: differences
  logic                  v1_r;
  logic [12*W-1:0]       pts1_r;
  logic signed [DW1-1:0] s1_r  [3][3];
  logic signed [DW1-1:0] eac1_r [3];
  logic signed [DW1-1:0] vv1_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pts1_r[i*W +: W]     <= a_in[i];
        pts1_r[(3+i)*W +: W] <= b_in[i];
        pts1_r[(6+i)*W +: W] <= c_in[i];
        pts1_r[(9+i)*W +: W] <= q_in[i];
        s1_r[0][i]  <= DW1'(b_in[i]) - DW1'(a_in[i]);
        s1_r[1][i]  <= DW1'(c_in[i]) - DW1'(b_in[i]);
        s1_r[2][i]  <= DW1'(a_in[i]) - DW1'(c_in[i]);
        eac1_r[i]   <= DW1'(c_in[i]) - DW1'(a_in[i]);
        vv1_r[0][i] <= DW1'(q_in[i]) - DW1'(a_in[i]);
        vv1_r[1][i] <= DW1'(q_in[i]) - DW1'(b_in[i]);
        vv1_r[2][i] <= DW1'(q_in[i]) - DW1'(c_in[i]);
      end
    end
  end

  // stage 2: cross products and edge dots
  logic                  v2_r;
  logic [12*W-1:0]       pts2_r;
  logic signed [CW-1:0]  n2_r  [3];
  logic signed [CW-1:0]  c2_r  [3][3];
  logic signed [EDW-1:0] ss2_r [3];
  logic signed [EDW-1:0] vs2_r [3];
  logic signed [DW1-1:0] s2_r  [3][3];
  logic signed [DW1-1:0] va2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pts2_r  <= pts1_r;
      n2_r[0] <= xmul(s1_r[0][1], eac1_r[2], s1_r[0][2], eac1_r[1]);
      n2_r[1] <= xmul(s1_r[0][2], eac1_r[0], s1_r[0][0], eac1_r[2]);
      n2_r[2] <= xmul(s1_r[0][0], eac1_r[1], s1_r[0][1], eac1_r[0]);
      for (int e = 0; e < 3; e++) begin
        c2_r[e][0] <= xmul(s1_r[e][1], vv1_r[e][2], s1_r[e][2], vv1_r[e][1]);
        c2_r[e][1] <= xmul(s1_r[e][2], vv1_r[e][0], s1_r[e][0], vv1_r[e][2]);
        c2_r[e][2] <= xmul(s1_r[e][0], vv1_r[e][1], s1_r[e][1], vv1_r[e][0]);
        ss2_r[e] <= dots(s1_r[e][0], s1_r[e][1], s1_r[e][2],
                         s1_r[e][0], s1_r[e][1], s1_r[e][2]);
        vs2_r[e] <= dots(vv1_r[e][0], vv1_r[e][1], vv1_r[e][2],
                         s1_r[e][0], s1_r[e][1], s1_r[e][2]);
        for (int i = 0; i < 3; i++) begin
          s2_r[e][i] <= s1_r[e][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        va2_r[i] <= vv1_r[0][i];
      end
    end
  end

  // stage 3: norm, plane distance, inside test, clamp modes
  ctl_t                  ctl3_nxt;
  ctl_t                  ctl3_r;
  logic [12*W-1:0]       pts3_r;
  logic signed [NNW-1:0] nn2;
  logic signed [NNW-1:0] nn3_r;
  logic signed [DDW-1:0] dd3_r;
  logic signed [CW-1:0]  n3_r  [3];
  logic signed [EDW-1:0] ss3_r [3];
  logic signed [TNW-1:0] tn3_r [3][3];
  logic signed [NNW-1:0] cdn   [3];
  logic [2:0]            hside;

  assign nn2 = dotc(n2_r[0], n2_r[1], n2_r[2], n2_r[0], n2_r[1], n2_r[2]);

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      cdn[e]   = dotc(c2_r[e][0], c2_r[e][1], c2_r[e][2], n2_r[0], n2_r[1], n2_r[2]);
      hside[e] = ~cdn[e][NNW-1];
    end
    ctl3_nxt.valid   = v2_r;
    ctl3_nxt.in_face = (nn2 != '0) && (&hside);
    for (int e = 0; e < 3; e++) begin
      if (ss2_r[e] == '0 || vs2_r[e][EDW-1]) begin
        ctl3_nxt.mode[e] = MODE_START;
      end else if (vs2_r[e] > ss2_r[e]) begin
        ctl3_nxt.mode[e] = MODE_END;
      end else begin
        ctl3_nxt.mode[e] = MODE_MID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else if (en) begin
      ctl3_r <= ctl3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pts3_r <= pts2_r;
      nn3_r  <= nn2;
      dd3_r  <= DDW'(n2_r[0]) * DDW'(va2_r[0]) + DDW'(n2_r[1]) * DDW'(va2_r[1])
              + DDW'(n2_r[2]) * DDW'(va2_r[2]);
      for (int e = 0; e < 3; e++) begin
        n3_r[e]  <= n2_r[e];
        ss3_r[e] <= ss2_r[e];
        for (int i = 0; i < 3; i++) begin
          tn3_r[e][i] <= TNW'(vs2_r[e]) * TNW'(s2_r[e][i]);
        end
      end
    end
  end

  // stage 4: face dividend as two partial products, high and low half
  ctl_t                  ctl4_r;
  logic [12*W-1:0]       pts4_r;
  logic [NNW-1:0]        nn4_r;
  logic signed [HIB-1:0] ddh3;
  logic signed [LOB:0]   ddl3;
  logic signed [PHW-1:0] ph4_r [3];
  logic signed [PLW-1:0] pl4_r [3];
  logic signed [EDW-1:0] ss4_r [3];
  logic signed [TNW-1:0] tn4_r [3][3];

  assign ddh3 = dd3_r[DDW-1:LOB];
  assign ddl3 = {1'b0, dd3_r[LOB-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
    end else if (en) begin
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pts4_r <= pts3_r;
      nn4_r  <= $unsigned(nn3_r);
      for (int i = 0; i < 3; i++) begin
        ph4_r[i] <= PHW'(ddh3) * PHW'(n3_r[i]);
        pl4_r[i] <= PLW'(ddl3) * PLW'(n3_r[i]);
      end
      for (int e = 0; e < 3; e++) begin
        ss4_r[e] <= ss3_r[e];
        for (int i = 0; i < 3; i++) begin
          tn4_r[e][i] <= tn3_r[e][i];
        end
      end
    end
  end

  // stage 5: lane operands, face lanes share the first edge's lanes
  ctl_t ctl5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r <= '0;
    end else if (en) begin
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pts <= pts4_r;
      for (int e = 0; e < 3; e++) begin
        for (int i = 0; i < 3; i++) begin
          if (e == 0 && ctl4_r.in_face) begin
            num[3*e+i] <= (NSW'(ph4_r[i]) <<< LOB) + NSW'(pl4_r[i]);
            den[3*e+i] <= nn4_r;
          end else begin
            num[3*e+i] <= NSW'(tn4_r[e][i]);
            den[3*e+i] <= NNW'($unsigned(ss4_r[e]));
          end
        end
      end
    end
  end

  assign ctl = ctl5_r;

endmodule

`default_nettype wire

@@ rtl/cpt_back.sv @@
// ----------------------------------------------------------------------------
// cpt_back: result back end
// Candidate points, squared distances, edge choice and saturation,
// over three register stages ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_back import cpt_pkg::*; #(
  parameter  int W   = 16,
  localparam int QOW = W+2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire ctl_t                  ctl,
  input  wire logic [12*W-1:0]       pts,
  input  wire logic signed [QOW-1:0] quo [9],
  output logic                       out_valid,
  output logic signed [W-1:0]        p_x,
  output logic signed [W-1:0]        p_y,
  output logic signed [W-1:0]        p_z,
  output logic [1:0]                 feature
);

  localparam int RW  = W+3;
  localparam int DFW = W+4;
  localparam int DSW = 2*W+10;

  function automatic logic signed [W-1:0] sat(input logic signed [RW-1:0] v);
    if (v[RW-1:W-1] == {(RW-W+1){v[RW-1]}}) begin
      return v[W-1:0];
    end else if (v[RW-1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // unpack corners and query point
  logic signed [W-1:0] p0 [3][3];
  logic signed [W-1:0] p1 [3][3];
  logic signed [W-1:0] pq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0[0][i] = pts[i*W +: W];
      p1[0][i] = pts[(3+i)*W +: W];
      p0[1][i] = pts[(3+i)*W +: W];
      p1[1][i] = pts[(6+i)*W +: W];
      p0[2][i] = pts[(6+i)*W +: W];
      p1[2][i] = pts[i*W +: W];
      pq[i]    = pts[(9+i)*W +: W];
    end
  end

  // stage 1: face point and the edge points of AB, BC and CA
  ctl_t                 ctl1_r;
  logic signed [RW-1:0] pt1_nxt [4][3];
  logic signed [RW-1:0] pt1_r   [4][3];
  logic signed [W-1:0]  q1_r    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt1_nxt[0][i] = RW'(pq[i]) - RW'(quo[i]);
    end
    for (int e = 0; e < 3; e++) begin
      for (int i = 0; i < 3; i++) begin
        case (ctl.mode[e])
          MODE_START: pt1_nxt[e+1][i] = RW'(p0[e][i]);
          MODE_END:   pt1_nxt[e+1][i] = RW'(p1[e][i]);
          default:    pt1_nxt[e+1][i] = RW'(p0[e][i]) + RW'(quo[3*e+i]);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt1_r <= pt1_nxt;
      q1_r  <= pq;
    end
  end

  // stage 2: squared distances to the edge points
  ctl_t                  ctl2_r;
  logic signed [RW-1:0]  pt2_r   [4][3];
  logic signed [DFW-1:0] dq      [3][3];
  logic signed [DSW-1:0] dist2_r [3];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      for (int i = 0; i < 3; i++) begin
        dq[e][i] = DFW'(q1_r[i]) - DFW'(pt1_r[e+1][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (en) begin
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt2_r <= pt1_r;
      for (int e = 0; e < 3; e++) begin
        dist2_r[e] <= DSW'(dq[e][0]) * DSW'(dq[e][0]) + DSW'(dq[e][1]) * DSW'(dq[e][1])
                    + DSW'(dq[e][2]) * DSW'(dq[e][2]);
      end
    end
  end

  // stage 3: pick the feature, saturate into the output register
  logic [1:0] feat_nxt;

  always_comb begin
    if (ctl2_r.in_face) begin
      feat_nxt = FEAT_FACE;
    end else if (dist2_r[0] <= dist2_r[1] && dist2_r[0] <= dist2_r[2]) begin
      feat_nxt = FEAT_AB;
    end else if (dist2_r[1] <= dist2_r[2]) begin
      feat_nxt = FEAT_BC;
    end else begin
      feat_nxt = FEAT_CA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_x     <= sat(pt2_r[feat_nxt][0]);
      p_y     <= sat(pt2_r[feat_nxt][1]);
      p_z     <= sat(pt2_r[feat_nxt][2]);
      feature <= feat_nxt;
    end
  end

endmodule

`default_nettype wire

@@ test/cpt_scoreboard.sv @@
// ----------------------------------------------------------------------------
// cpt_scoreboard: result checker for the triangle closest point unit
// Watches both channels, predicts the closest point and feature of every
// accepted input beat in exact wide integer math, and compares each output
// beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_scoreboard import cpt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic signed [15:0] in_a_x,
  input  wire logic signed [15:0] in_a_y,
  input  wire logic signed [15:0] in_a_z,
  input  wire logic signed [15:0] in_b_x,
  input  wire logic signed [15:0] in_b_y,
  input  wire logic signed [15:0] in_b_z,
  input  wire logic signed [15:0] in_c_x,
  input  wire logic signed [15:0] in_c_y,
  input  wire logic signed [15:0] in_c_z,
  input  wire logic signed [15:0] in_q_x,
  input  wire logic signed [15:0] in_q_y,
  input  wire logic signed [15:0] in_q_z,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [15:0] out_p_x,
  input  wire logic signed [15:0] out_p_y,
  input  wire logic signed [15:0] out_p_z,
  input  wire logic [1:0]         out_feature,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wint_t;
  typedef wint_t vec3_t [3];

  typedef struct {
    logic signed [15:0] p[3];
    logic [1:0]         feat;
  } point_t;

  point_t closest_q[$];

  function automatic vec3_t vsub(vec3_t u, vec3_t w);
    vec3_t r;
    for (int i = 0; i < 3; i++) r[i] = u[i] - w[i];
    return r;
  endfunction

  function automatic vec3_t vcross(vec3_t u, vec3_t w);
    vec3_t r;
    r[0] = u[1] * w[2] - u[2] * w[1];
    r[1] = u[2] * w[0] - u[0] * w[2];
    r[2] = u[0] * w[1] - u[1] * w[0];
    return r;
  endfunction

  function automatic wint_t vdot(vec3_t u, vec3_t w);
    return u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
  endfunction

  // nearest point of segment p0-p1, clamped; start point if degenerate
  function automatic vec3_t seg_near(vec3_t p0, vec3_t p1, vec3_t q);
    vec3_t s, v, p;
    wint_t ss, vs;
    s  = vsub(p1, p0);
    v  = vsub(q, p0);
    ss = vdot(s, s);
    vs = vdot(v, s);
    for (int i = 0; i < 3; i++) begin
      if (ss == 0 || vs < 0) p[i] = p0[i];
      else if (vs > ss) p[i] = p1[i];
      else p[i] = p0[i] + (vs * s[i]) / ss;
    end
    return p;
  endfunction

  function automatic logic edge_in(vec3_t p0, vec3_t p1, vec3_t q, vec3_t n);
    return vdot(vcross(vsub(p1, p0), vsub(q, p0)), n) >= 0;
  endfunction

  function automatic logic signed [15:0] sat16(wint_t v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic point_t predict_closest(vec3_t a, vec3_t b, vec3_t c, vec3_t q);
    vec3_t n, res, pab, pbc, pca;
    wint_t nn, dd, dab, dbc, dca;
    point_t o;
    n  = vcross(vsub(b, a), vsub(c, a));
    nn = vdot(n, n);
    if (nn != 0 && edge_in(a, b, q, n) && edge_in(b, c, q, n) && edge_in(c, a, q, n)) begin
      dd = vdot(n, vsub(q, a));
      for (int i = 0; i < 3; i++) res[i] = q[i] - (dd * n[i]) / nn;
      o.feat = FEAT_FACE;
    end else begin
      pab = seg_near(a, b, q);
      pbc = seg_near(b, c, q);
      pca = seg_near(c, a, q);
      dab = vdot(vsub(q, pab), vsub(q, pab));
      dbc = vdot(vsub(q, pbc), vsub(q, pbc));
      dca = vdot(vsub(q, pca), vsub(q, pca));
      // ties go to the earlier edge
      if (dab <= dbc && dab <= dca) begin
        res = pab;
        o.feat = FEAT_AB;
      end else if (dbc <= dca) begin
        res = pbc;
        o.feat = FEAT_BC;
      end else begin
        res = pca;
        o.feat = FEAT_CA;
      end
    end
    for (int i = 0; i < 3; i++) o.p[i] = sat16(res[i]);
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = closest_q.size();

  // predict on input beats, compare on output beats
  always @(posedge clk) begin
    vec3_t a, b, c, q;
    point_t e;
    if (rst_n && in_valid && !in_stall) begin
      a = '{in_a_x, in_a_y, in_a_z};
      b = '{in_b_x, in_b_y, in_b_z};
      c = '{in_c_x, in_c_y, in_c_z};
      q = '{in_q_x, in_q_y, in_q_z};
      closest_q.push_back(predict_closest(a, b, c, q));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (closest_q.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        e = closest_q.pop_front();
        if (out_p_x != e.p[0]) report("p_x", out_p_x, e.p[0]);
        if (out_p_y != e.p[1]) report("p_y", out_p_y, e.p[1]);
        if (out_p_z != e.p[2]) report("p_z", out_p_z, e.p[2]);
        if (out_feature != e.feat) report("feature", out_feature, e.feat);
      end
    end
  end

endmodule

`default_nettype wire

@@ test/tb_triangle_closest_point_unit.sv @@
// ----------------------------------------------------------------------------
// tb_triangle_closest_point_unit: regression of the closest point unit
// Drives directed corner cases and then random triangles, many of them
// with the query point above the face, under random gaps and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_triangle_closest_point_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM  = 1430;
  localparam int MAX_CYCLE = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid;
  logic signed [15:0] fld [12];
  logic signed [15:0] out_p_x, out_p_y, out_p_z;
  logic [1:0] out_feature;
  int fail_count, pending;
  int cycle = 0;
  logic quiet = 1'b0;
  logic signed [15:0] beat [12];

  always #5 clk = ~clk;

  triangle_closest_point_unit #(.COORD_WIDTH(16)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_a_x(fld[0]), .in_a_y(fld[1]), .in_a_z(fld[2]),
    .in_b_x(fld[3]), .in_b_y(fld[4]), .in_b_z(fld[5]),
    .in_c_x(fld[6]), .in_c_y(fld[7]), .in_c_z(fld[8]),
    .in_q_x(fld[9]), .in_q_y(fld[10]), .in_q_z(fld[11]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_p_x(out_p_x), .out_p_y(out_p_y), .out_p_z(out_p_z),
    .out_feature(out_feature)
  );

  cpt_scoreboard i_scoreboard (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_a_x(fld[0]), .in_a_y(fld[1]), .in_a_z(fld[2]),
    .in_b_x(fld[3]), .in_b_y(fld[4]), .in_b_z(fld[5]),
    .in_c_x(fld[6]), .in_c_y(fld[7]), .in_c_z(fld[8]),
    .in_q_x(fld[9]), .in_q_y(fld[10]), .in_q_z(fld[11]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_p_x(out_p_x), .out_p_y(out_p_y), .out_p_z(out_p_z),
    .out_feature(out_feature),
    .fail_count(fail_count), .pending(pending)
  );

  initial for (int i = 0; i < 12; i++) fld[i] = '0;

  // cycle count, watchdog and random output stall
  always @(posedge clk) begin
    cycle <= cycle + 1;
    out_stall <= (!quiet && $urandom_range(99) < 16);
    if (cycle > MAX_CYCLE) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one input beat with a random gap ahead of it
  task automatic send_beat();
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 12; i++) fld[i] <= beat[i];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_all(int v);
    for (int i = 0; i < 12; i++) beat[i] = 16'(v);
    send_beat();
  endtask

  // triangle from coordinate list: a, b, c, q
  task automatic send_tri(int ax, int ay, int az, int bx, int by, int bz,
                          int cx, int cy, int cz, int qx, int qy, int qz);
    beat = '{16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz),
             16'(cx), 16'(cy), 16'(cz), 16'(qx), 16'(qy), 16'(qz)};
    send_beat();
  endtask

  function automatic int rsmall(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // random beat shapes: wide noise, local triangles, flat ones, face hits
  task automatic send_random();
    int kind, w1, w2;
    kind = $urandom_range(99);
    if (kind < 25) begin
      for (int i = 0; i < 12; i++) beat[i] = 16'($urandom());
    end else if (kind < 55) begin
      for (int i = 0; i < 12; i++) beat[i] = 16'(rsmall(4000));
    end else if (kind < 65) begin
      // collinear or repeated corners
      for (int i = 0; i < 3; i++) begin
        beat[i] = 16'(rsmall(3000));
        beat[3 + i] = ($urandom_range(1)) ? beat[i] : 16'(beat[i] + rsmall(2000));
        beat[6 + i] = 16'(beat[i] + 2 * (beat[3 + i] - beat[i]));
        beat[9 + i] = 16'(rsmall(6000));
      end
    end else begin
      // query point above the face, near its plane
      w1 = $urandom_range(256);
      w2 = $urandom_range(256 - w1);
      for (int i = 0; i < 9; i++) beat[i] = 16'(rsmall(3000));
      for (int i = 0; i < 3; i++)
        beat[9 + i] = 16'(beat[i] + (w1 * (beat[3 + i] - beat[i]) +
                      w2 * (beat[6 + i] - beat[i])) / 256 + rsmall(300));
    end
    send_beat();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_all(0);
    send_all(32767);
    send_all(-32768);
    send_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768,
             32767, 32767, 32767);
    send_tri(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767,
             -32768, -32768, -32768);
    send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 500);
    send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, -500);
    send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0);
    send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 128, 0, 0);
    send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 128, -300, 40);
    send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 300, 300, 0);
    send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, -300, 128, 7);
    send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, -100, -100, 0);
    send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 500, -100, 0);
    send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 128, 128, 0);
    // flat triangles and repeated corners
    send_tri(100, 100, 100, 100, 100, 100, 100, 100, 100, 0, 0, 0);
    send_tri(0, 0, 0, 0, 0, 0, 512, 512, 0, 100, 400, 9);
    send_tri(0, 0, 0, 256, 256, 256, 512, 512, 512, 0, 900, -3);
    send_tri(0, 0, 0, 256, 0, 0, 256, 0, 0, 128, 50, 50);
    send_tri(-32768, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 32767, -32768);
    send_tri(-32768, -32768, 0, 32767, 32767, 0, 32767, -32768, 0, 0, 0, 32767);

    // random part with one long stretch free of gaps and stalls
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 500 && n < 700);
      send_random();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/cpt_pkg.sv
rtl/cpt_div.sv
rtl/cpt_front.sv
rtl/cpt_back.sv
rtl/triangle_closest_point_unit.sv
test/cpt_scoreboard.sv
test/tb_triangle_closest_point_unit.sv
